// File: rtl/ihcb_pkg.sv
// Shared types and constants of the IPv4 header check and build unit.
`timescale 1ns / 1ps
package ihcb_pkg;

  // Header geometry and fixed field values
  localparam int unsigned HDR_WORDS       = 10;
  localparam int unsigned WORD_IDX_W      = 4;
  localparam logic [15:0] LINK_HDR_BYTES  = 16'd14;
  localparam logic [7:0]  PROTO_TCP       = 8'h06;
  localparam logic [7:0]  PROTO_UDP       = 8'h11;
  localparam logic [7:0]  TTL_VALUE       = 8'd64;
  localparam logic [7:0]  VER_IHL         = 8'((4 << 4) + 5);
  localparam logic [15:0] FLAGS_DF        = 16'((1 << 6) << 8);
  localparam logic [15:0] SUM_PASS        = 16'hFFFF;
  localparam logic [15:0] SUM_ZERO        = 16'h0000;
  // Raw sum of nine 16-bit terms fits in 20 bits
  localparam int unsigned RAW_SUM_W       = 20;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Input function codes
  typedef enum logic {
    FUNC_RX = 1'b0,
    FUNC_TX = 1'b1
  } func_e;

  // Result kinds
  typedef enum logic {
    KIND_RX = 1'b0,
    KIND_TX = 1'b1
  } kind_e;

  // Receive verdicts
  typedef enum logic [1:0] {
    VERDICT_TCP       = 2'd0,
    VERDICT_UDP       = 2'd1,
    VERDICT_DROP_PROT = 2'd2,
    VERDICT_DROP_CSUM = 2'd3
  } verdict_e;

  // One queued command from front to back
  typedef struct packed {
    kind_e                  kind;
    verdict_e               verdict;
    logic                   warn;
    logic [15:0]            total_len;
    logic [15:0]            ident;
    logic [7:0]             proto;
    logic [31:0]            src;
    logic [31:0]            dst;
    logic [RAW_SUM_W-1:0]   raw_sum;
  } cmd_t;

endpackage

// File: rtl/ihcb_if.sv
// Valid/ready channel interfaces for the input and result streams.
`timescale 1ns / 1ps
interface ihcb_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] rx_word;
  logic [15:0] frame_length;
  logic        upper_protocol;
  logic [31:0] source_address;
  logic [31:0] destination_address;

  modport source (
    output valid, func, rx_word, frame_length, upper_protocol,
           source_address, destination_address,
    input  ready
  );
  modport sink (
    input  valid, func, rx_word, frame_length, upper_protocol,
           source_address, destination_address,
    output ready
  );
endinterface

interface ihcb_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [1:0]  verdict;
  logic        zero_sum_warning;
  logic [15:0] header_word;
  logic        word_last;

  modport source (
    output valid, result_kind, verdict, zero_sum_warning, header_word, word_last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, verdict, zero_sum_warning, header_word, word_last,
    output ready
  );
endinterface

// File: rtl/ihcb_front.sv
// Front end: takes input transfers, runs the receive checksum and queues commands.
`timescale 1ns / 1ps
module ihcb_front import ihcb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ihcb_in_if.sink     in_i,
  input  logic        q_ready_i,
  output logic        q_push_o,
  output cmd_t        q_cmd_o
);

  logic [15:0]           ident_q, ident_d;
  logic [15:0]           rx_sum_q, rx_sum_d;
  logic [WORD_IDX_W-1:0] rx_cnt_q, rx_cnt_d;
  logic [7:0]            rx_prot_q, rx_prot_d;

  logic                  fire;
  logic                  is_tx;
  logic                  last_word;
  logic [16:0]           sum_wide;
  logic [15:0]           sum_new;
  verdict_e              verdict;
  logic                  warn;
  logic [7:0]            tx_proto;
  logic [15:0]           tx_len;
  logic [RAW_SUM_W-1:0]  tx_raw;

  assign in_i.ready = q_ready_i;
  assign fire       = in_i.valid && in_i.ready;
  assign is_tx      = (in_i.func == FUNC_TX);
  assign last_word  = (rx_cnt_q == WORD_IDX_W'(HDR_WORDS - 1));

  // Ones' complement add of the incoming word
  assign sum_wide = {1'b0, rx_sum_q} + {1'b0, in_i.rx_word};
  assign sum_new  = sum_wide[15:0] + {15'd0, sum_wide[16]};

  // Verdict on the tenth word
  always_comb begin
    warn    = 1'b0;
    verdict = VERDICT_DROP_CSUM;
    if (sum_new == SUM_PASS || sum_new == SUM_ZERO) begin
      warn = (sum_new == SUM_ZERO);
      if (rx_prot_q == PROTO_TCP) begin
        verdict = VERDICT_TCP;
      end else if (rx_prot_q == PROTO_UDP) begin
        verdict = VERDICT_UDP;
      end else begin
        verdict = VERDICT_DROP_PROT;
      end
    end
  end

  // Transmit header fields and the raw (unfolded) sum of all words but the checksum
  assign tx_proto = in_i.upper_protocol ? PROTO_UDP : PROTO_TCP;
  assign tx_len   = in_i.frame_length - LINK_HDR_BYTES;
  assign tx_raw   = RAW_SUM_W'({VER_IHL, 8'h00})
                  + RAW_SUM_W'(tx_len)
                  + RAW_SUM_W'(ident_q)
                  + RAW_SUM_W'(FLAGS_DF)
                  + RAW_SUM_W'({TTL_VALUE, tx_proto})
                  + RAW_SUM_W'(in_i.source_address[31:16])
                  + RAW_SUM_W'(in_i.source_address[15:0])
                  + RAW_SUM_W'(in_i.destination_address[31:16])
                  + RAW_SUM_W'(in_i.destination_address[15:0]);

  // Command to the queue
  assign q_push_o = fire && (is_tx || last_word);
  always_comb begin
    q_cmd_o           = '0;
    q_cmd_o.kind      = is_tx ? KIND_TX : KIND_RX;
    q_cmd_o.verdict   = is_tx ? VERDICT_TCP : verdict;
    q_cmd_o.warn      = is_tx ? 1'b0 : warn;
    q_cmd_o.total_len = tx_len;
    q_cmd_o.ident     = ident_q;
    q_cmd_o.proto     = tx_proto;
    q_cmd_o.src       = in_i.source_address;
    q_cmd_o.dst       = in_i.destination_address;
    q_cmd_o.raw_sum   = tx_raw;
  end

  // Receive and identification state update
  always_comb begin
    ident_d   = ident_q;
    rx_sum_d  = rx_sum_q;
    rx_cnt_d  = rx_cnt_q;
    rx_prot_d = rx_prot_q;
    if (fire) begin
      if (is_tx) begin
        ident_d = ident_q + 16'd1;
      end else if (last_word) begin
        rx_sum_d  = '0;
        rx_cnt_d  = '0;
        rx_prot_d = '0;
      end else begin
        rx_sum_d = sum_new;
        rx_cnt_d = rx_cnt_q + WORD_IDX_W'(1);
        if (rx_cnt_q == WORD_IDX_W'(4)) begin
          rx_prot_d = in_i.rx_word[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ident_q   <= '0;
      rx_sum_q  <= '0;
      rx_cnt_q  <= '0;
      rx_prot_q <= '0;
    end else begin
      ident_q   <= ident_d;
      rx_sum_q  <= rx_sum_d;
      rx_cnt_q  <= rx_cnt_d;
      rx_prot_q <= rx_prot_d;
    end
  end

endmodule

// File: rtl/ihcb_fifo.sv
// Short command queue between front end and back end.
`timescale 1ns / 1ps
module ihcb_fifo import ihcb_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic ready_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign ready_o = (cnt_q != CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/ihcb_back.sv
// Back end: finishes the checksum and emits verdicts and header words.
`timescale 1ns / 1ps
module ihcb_back import ihcb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  cmd_t        q_cmd_i,
  output logic        q_pop_o,
  ihcb_out_if.source  out_o
);

  logic                  busy_q, busy_d;
  logic [WORD_IDX_W-1:0] idx_q, idx_d;
  cmd_t                  cmd_q;
  logic [15:0]           csum_q;

  logic                  fire;
  logic                  last;
  logic [16:0]           fold1;
  logic [15:0]           fold2;
  logic [15:0]           word;

  assign last    = (cmd_q.kind == KIND_RX) || (idx_q == WORD_IDX_W'(HDR_WORDS - 1));
  assign fire    = busy_q && out_o.ready;
  assign q_pop_o = q_valid_i && (!busy_q || (fire && last));

  // End-around fold of the raw sum
  assign fold1 = {1'b0, q_cmd_i.raw_sum[15:0]}
               + 17'(q_cmd_i.raw_sum[RAW_SUM_W-1:16]);
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

  // Header word select
  always_comb begin
    unique case (idx_q)
      4'd0:    word = {VER_IHL, 8'h00};
      4'd1:    word = cmd_q.total_len;
      4'd2:    word = cmd_q.ident;
      4'd3:    word = FLAGS_DF;
      4'd4:    word = {TTL_VALUE, cmd_q.proto};
      4'd5:    word = csum_q;
      4'd6:    word = cmd_q.src[31:16];
      4'd7:    word = cmd_q.src[15:0];
      4'd8:    word = cmd_q.dst[31:16];
      4'd9:    word = cmd_q.dst[15:0];
      default: word = '0;
    endcase
  end

  assign out_o.valid            = busy_q;
  assign out_o.result_kind      = cmd_q.kind;
  assign out_o.verdict          = cmd_q.verdict;
  assign out_o.zero_sum_warning = cmd_q.warn;
  assign out_o.header_word      = (cmd_q.kind == KIND_TX) ? word : 16'd0;
  assign out_o.word_last        = last;

  // Sequencing over the words of one command
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (q_pop_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (fire && last) begin
      busy_d = 1'b0;
    end else if (fire) begin
      idx_d = idx_q + WORD_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  // Command payload and checksum
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q  <= q_cmd_i;
      csum_q <= ~fold2;
    end
  end

endmodule

// File: rtl/ipv4_header_check_and_build_unit.sv
// Top level of the IPv4 header check and build unit.
//
// Usage:
//   in_i carries one item per transfer. func = 0 feeds one received header
//   word (big-endian); every tenth such word closes a header and yields one
//   verdict result. func = 1 requests a transmit header and yields ten
//   header word results, word_last set on the tenth.
//   out_o carries results; result_kind tells verdicts from header words.
// Timing: a result is presented once its command has passed the queue and
//   then the back end's command register. A transmit header streams one
//   word per cycle while out_o.ready stays high.
// Throughput: receive words are taken one per cycle while the queue has room.
//   The back end emits one result per cycle while out_o.ready is high, and
//   each transmit request takes ten of them; the command queue (QUEUE_DEPTH entries) absorbs bursts.
// Stalls: when out_o.ready is low the current result holds; in_i keeps
//   taking items until the queue is full, then in_i.ready drops.
// Reset: asynchronous, active low. Clears the receive sum, word count and
//   protocol, the identification counter, the queue and the back end's sequencer.
`timescale 1ns / 1ps
module ipv4_header_check_and_build_unit import ihcb_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ihcb_in_if.sink    in_i,
  ihcb_out_if.source out_o
);

  logic q_push;
  logic q_ready;
  logic q_valid;
  logic q_pop;
  cmd_t q_wr_cmd;
  cmd_t q_rd_cmd;

  ihcb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_cmd_o   (q_wr_cmd)
  );

  ihcb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wr_cmd),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_rd_cmd)
  );

  ihcb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_rd_cmd),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

  // A verdict is always a single, last result with no header word
  a_verdict_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.result_kind == KIND_RX) |->
      (out_o.word_last && out_o.header_word == 16'd0))
    else $error("verdict result without word_last or with a header word");

  // Transmit words carry no verdict and no warning
  a_tx_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.result_kind == KIND_TX) |->
      (out_o.verdict == VERDICT_TCP && !out_o.zero_sum_warning))
    else $error("transmit word with verdict or warning set");

  // A non-final transmit transfer is followed by another transmit word
  a_tx_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.result_kind == KIND_TX && !out_o.word_last) |=>
      (out_o.valid && out_o.result_kind == KIND_TX))
    else $error("transmit header interrupted");

  // The front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> q_ready)
    else $error("command queue overflow");

endmodule
